/* rtl/coalescing_event_queue_assert.svh */
// Assertion macros used by the coalescing event queue port checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef COALESCING_EVENT_QUEUE_ASSERT_SVH
`define COALESCING_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CEQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ceq_pkg.sv */
// Package for the coalescing event queue: transfer structs, action and kind codes.
// Used by the top level, its checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ceq_pkg;

  localparam int WINDOW_COUNT = 32;

  localparam logic [2:0] ACT_PUSH       = 3'd0;
  localparam logic [2:0] ACT_POP        = 3'd1;
  localparam logic [2:0] ACT_CLEAR      = 3'd2;
  localparam logic [2:0] ACT_RESET_CNT  = 3'd3;
  localparam logic [2:0] ACT_QUIT       = 3'd4;

  localparam logic [3:0] KIND_NONE         = 4'd0;
  localparam logic [3:0] KIND_QUIT         = 4'd1;
  localparam logic [3:0] KIND_CLOSE        = 4'd2;
  localparam logic [3:0] KIND_RESIZE       = 4'd3;
  localparam logic [3:0] KIND_FOCUS_GAINED = 4'd4;
  localparam logic [3:0] KIND_FOCUS_LOST   = 4'd5;
  localparam logic [3:0] KIND_LAST         = 4'd11;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         event_kind;
    logic               has_window;
    logic [4:0]         window_id;
    logic [15:0]        new_width;
    logic [15:0]        new_height;
    logic [31:0]        code;
    logic signed [31:0] pointer_x;
    logic signed [31:0] pointer_y;
  } in_t;

  typedef struct packed {
    logic               popped_valid;
    logic [3:0]         out_kind;
    logic [5:0]         out_window;
    logic [15:0]        out_width;
    logic [15:0]        out_height;
    logic [31:0]        out_code;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [5:0]         pending_count;
    logic [31:0]        dropped_count;
    logic [31:0]        coalesced_count;
    logic               quit_flag;
  } out_t;

endpackage

`default_nettype wire

/* rtl/ceq_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the queue instantiates one per slice of an event.
`timescale 1ns / 1ps
`default_nettype none

module ceq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/coalescing_event_queue.sv */
// Coalescing event queue top level: ring FIFO in three RAMs and a small sequencer.
// Depends on ceq_pkg and ceq_ram.
//
// A command is taken when start is high and busy is low; its single result
// appears on result with done high for exactly one cycle, and the receiver
// cannot stall it. Clear, counter reset, ignored pushes, pops of an empty
// queue and unknown actions go from idle straight to the result state; an
// enqueue or request-quit passes through S_ENQ first, and a pop that returns
// an event through S_POP and S_POPD. A resize push that carries a window and
// a nonzero size into a nonempty queue scans the queue newest first through
// the tag RAM read port, one entry per cycle, down to the oldest entry;
// a match ends the scan early.
`timescale 1ns / 1ps
`default_nettype none

module coalescing_event_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire ceq_pkg::in_t request,
  output logic              done,
  output ceq_pkg::out_t     result
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_W  = (IW+1)'(QUEUE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ENQ  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_POPD = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic [2:0]    state;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [31:0]   drop_cnt;
  logic [31:0]   merge_cnt;
  logic          quit_seen;

  logic [3:0]    req_kind;
  logic [5:0]    req_win;
  logic [31:0]   req_size;
  logic [31:0]   req_code;
  logic [63:0]   req_pos;

  logic [IW-1:0] scan_ptr;
  logic          scan_issue;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;
  logic          chk_last;

  logic          pop_valid;
  logic [3:0]    pop_kind;
  logic [5:0]    pop_window;
  logic [31:0]   pop_size;
  logic [31:0]   pop_code;
  logic [63:0]   pop_pos;

  logic [9:0]    tag_rd;
  logic [31:0]   size_rd;
  logic [95:0]   data_rd;

  logic          accept;
  logic          empty;
  logic          full;
  logic [5:0]    in_win;
  logic          in_kind_ok;
  logic          in_scoped;
  logic          in_merge_try;
  logic          tag_match;
  logic          merge_hit;
  logic          enq_write;
  logic [IW:0]   pend_wide;

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESP);
  assign accept = start && !busy;
  assign empty  = (head == tail);
  assign full   = (idx_next(tail) == head);

  assign in_win = (request.has_window && (int'(request.window_id) < ceq_pkg::WINDOW_COUNT))
                  ? {1'b1, request.window_id} : 6'd0;
  assign in_kind_ok = (request.event_kind != ceq_pkg::KIND_NONE)
                      && (request.event_kind <= ceq_pkg::KIND_LAST);
  assign in_scoped = (request.event_kind == ceq_pkg::KIND_CLOSE)
                     || (request.event_kind == ceq_pkg::KIND_RESIZE)
                     || (request.event_kind == ceq_pkg::KIND_FOCUS_GAINED)
                     || (request.event_kind == ceq_pkg::KIND_FOCUS_LOST);
  assign in_merge_try = (request.event_kind == ceq_pkg::KIND_RESIZE) && in_win[5]
                        && (request.new_width != 16'd0) && (request.new_height != 16'd0)
                        && !empty;

  assign tag_match = (tag_rd[9:6] == ceq_pkg::KIND_RESIZE) && (tag_rd[5:0] == req_win);
  assign merge_hit = (state == S_SCAN) && chk_valid && tag_match;
  assign enq_write = (state == S_ENQ) && !full;

  ceq_ram #(.WIDTH(10), .DEPTH(QUEUE_DEPTH)) u_tag_ram (
    .clk     (clk),
    .wr_en   (enq_write),
    .wr_addr (tail),
    .wr_data ({req_kind, req_win}),
    .rd_en   (((state == S_SCAN) && scan_issue) || (state == S_POP)),
    .rd_addr ((state == S_SCAN) ? scan_ptr : head),
    .rd_data (tag_rd)
  );

  ceq_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_size_ram (
    .clk     (clk),
    .wr_en   (enq_write || merge_hit),
    .wr_addr (merge_hit ? chk_idx : tail),
    .wr_data (req_size),
    .rd_en   (state == S_POP),
    .rd_addr (head),
    .rd_data (size_rd)
  );

  ceq_ram #(.WIDTH(96), .DEPTH(QUEUE_DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   (enq_write),
    .wr_addr (tail),
    .wr_data ({req_code, req_pos}),
    .rd_en   (state == S_POP),
    .rd_addr (head),
    .rd_data (data_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      drop_cnt   <= '0;
      merge_cnt  <= '0;
      quit_seen  <= 1'b0;
      scan_issue <= 1'b0;
      chk_valid  <= 1'b0;
      pop_valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pop_valid  <= 1'b0;
            pop_kind   <= '0;
            pop_window <= '0;
            pop_size   <= '0;
            pop_code   <= '0;
            pop_pos    <= '0;
            req_kind   <= request.event_kind;
            req_win    <= in_win;
            req_size   <= {request.new_height, request.new_width};
            req_code   <= request.code;
            req_pos    <= {request.pointer_y, request.pointer_x};
            scan_ptr   <= idx_prev(tail);
            scan_issue <= 1'b1;
            chk_valid  <= 1'b0;
            unique case (request.action)
              ceq_pkg::ACT_PUSH: begin
                priority if (!in_kind_ok || (in_scoped && !in_win[5])) begin
                  state <= S_RESP;
                end else if (in_merge_try) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_ENQ;
                end
              end
              ceq_pkg::ACT_POP: begin
                state <= empty ? S_RESP : S_POP;
              end
              ceq_pkg::ACT_CLEAR: begin
                head      <= '0;
                tail      <= '0;
                quit_seen <= 1'b0;
                state     <= S_RESP;
              end
              ceq_pkg::ACT_RESET_CNT: begin
                drop_cnt  <= '0;
                merge_cnt <= '0;
                state     <= S_RESP;
              end
              ceq_pkg::ACT_QUIT: begin
                quit_seen <= 1'b1;
                req_kind  <= ceq_pkg::KIND_QUIT;
                req_win   <= '0;
                req_size  <= '0;
                req_code  <= '0;
                req_pos   <= '0;
                state     <= S_ENQ;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          chk_valid <= scan_issue;
          chk_idx   <= scan_ptr;
          chk_last  <= (scan_ptr == head);
          if (scan_issue) begin
            if (scan_ptr == head) begin
              scan_issue <= 1'b0;
            end else begin
              scan_ptr <= idx_prev(scan_ptr);
            end
          end
          priority if (merge_hit) begin
            merge_cnt <= merge_cnt + 32'd1;
            state     <= S_RESP;
          end else if (chk_valid && chk_last) begin
            state <= S_ENQ;
          end
        end
        S_ENQ: begin
          if (full) begin
            drop_cnt <= drop_cnt + 32'd1;
          end else begin
            tail <= idx_next(tail);
          end
          state <= S_RESP;
        end
        S_POP: begin
          state <= S_POPD;
        end
        S_POPD: begin
          pop_valid  <= 1'b1;
          pop_kind   <= tag_rd[9:6];
          pop_window <= tag_rd[5:0];
          pop_size   <= size_rd;
          pop_code   <= data_rd[95:64];
          pop_pos    <= data_rd[63:0];
          head       <= idx_next(head);
          if (tag_rd[9:6] == ceq_pkg::KIND_QUIT) begin
            quit_seen <= 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pend_wide = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                    : ({1'b0, tail} + DEPTH_W - {1'b0, head});

  always_comb begin
    result.popped_valid    = pop_valid;
    result.out_kind        = pop_kind;
    result.out_window      = pop_window;
    result.out_width       = pop_size[15:0];
    result.out_height      = pop_size[31:16];
    result.out_code        = pop_code;
    result.out_x           = pop_pos[31:0];
    result.out_y           = pop_pos[63:32];
    result.pending_count   = 6'(pend_wide);
    result.dropped_count   = drop_cnt;
    result.coalesced_count = merge_cnt;
    result.quit_flag       = quit_seen;
  end

endmodule

`default_nettype wire

/* rtl/ceq_checker.sv */
// Port-level checker for the coalescing event queue, bound to the top level.
// Depends on ceq_pkg and coalescing_event_queue_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "coalescing_event_queue_assert.svh"

module ceq_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire ceq_pkg::out_t result
);

  `CEQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "transfer did not raise busy")
  `CEQ_ASSERT_IMPLY(a_done_busy, clk, rst, done, busy, "result shown while idle")
  `CEQ_ASSERT_NEXT(a_done_single, clk, rst, done, !done && !busy, "result repeated")
  `CEQ_ASSERT_IMPLY(a_empty_pop_zero, clk, rst, done && !result.popped_valid, (result.out_kind == 4'd0) && (result.out_window == 6'd0) && (result.out_code == 32'd0), "event fields not zero")
  `CEQ_ASSERT_IMPLY(a_pop_kind, clk, rst, done && result.popped_valid, (result.out_kind != ceq_pkg::KIND_NONE) && (result.out_kind <= ceq_pkg::KIND_LAST), "popped event has bad kind")

endmodule

bind coalescing_event_queue ceq_checker u_ceq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

/* tb/sv/ceq_reply_checker.sv */
// Reply checker for the coalescing event queue: predicts each command's reply and compares it.
// Depends on ceq_pkg; watches the command and reply channels of coalescing_event_queue.
`timescale 1ns / 1ps

module ceq_reply_checker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ceq_pkg::in_t  request,
  input  logic          done,
  input  ceq_pkg::out_t result,
  output int            failures,
  output int            outstanding
);
  import ceq_pkg::*;

  logic [3:0]  slot_kind     [QUEUE_DEPTH];
  logic [5:0]  slot_window   [QUEUE_DEPTH];
  logic [31:0] slot_size     [QUEUE_DEPTH];
  logic [31:0] slot_code     [QUEUE_DEPTH];
  logic [63:0] slot_position [QUEUE_DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  logic [31:0] drop_total;
  logic [31:0] merge_total;
  logic        quit_raised;
  out_t        predicted_replies[$];
  out_t        oldest;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1) % QUEUE_DEPTH;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
  endfunction

  // Resizes with a window and a nonzero size fold into the newest queued resize
  // of the same window before any enqueue is tried.
  function automatic void store_event(logic [3:0] kind, logic [5:0] win, logic [15:0] w,
                                      logic [15:0] h, logic [31:0] code, logic [31:0] x,
                                      logic [31:0] y);
    int unsigned idx;
    if (kind == KIND_NONE || kind > KIND_LAST) return;
    if (kind inside {KIND_CLOSE, KIND_RESIZE, KIND_FOCUS_GAINED, KIND_FOCUS_LOST} && !win[5])
      return;
    if (kind == KIND_RESIZE && win[5] && w != 0 && h != 0 && head_pos != tail_pos) begin
      idx = ring_prev(tail_pos);
      forever begin
        if (slot_kind[idx] == KIND_RESIZE && slot_window[idx] == win) begin
          slot_size[idx] = {h, w};
          merge_total++;
          return;
        end
        if (idx == head_pos) break;
        idx = ring_prev(idx);
      end
    end
    if (ring_next(tail_pos) == head_pos) begin
      drop_total++;
      return;
    end
    slot_kind[tail_pos]     = kind;
    slot_window[tail_pos]   = win;
    slot_size[tail_pos]     = {h, w};
    slot_code[tail_pos]     = code;
    slot_position[tail_pos] = {y, x};
    tail_pos = ring_next(tail_pos);
  endfunction

  function automatic out_t predict_reply(in_t cmd);
    out_t        rep;
    logic [5:0]  win;
    int unsigned idx;
    rep = '0;
    win = (cmd.has_window && cmd.window_id < WINDOW_COUNT) ? {1'b1, cmd.window_id} : 6'd0;
    case (cmd.action)
      ACT_PUSH: begin
        store_event(cmd.event_kind, win, cmd.new_width, cmd.new_height, cmd.code,
                    cmd.pointer_x, cmd.pointer_y);
      end
      ACT_POP: begin
        if (head_pos != tail_pos) begin
          idx = head_pos;
          rep.popped_valid = 1'b1;
          rep.out_kind     = slot_kind[idx];
          rep.out_window   = slot_window[idx];
          rep.out_width    = slot_size[idx][15:0];
          rep.out_height   = slot_size[idx][31:16];
          rep.out_code     = slot_code[idx];
          rep.out_x        = slot_position[idx][31:0];
          rep.out_y        = slot_position[idx][63:32];
          if (slot_kind[idx] == KIND_QUIT) quit_raised = 1'b1;
          head_pos = ring_next(head_pos);
        end
      end
      ACT_CLEAR: begin
        head_pos    = 0;
        tail_pos    = 0;
        quit_raised = 1'b0;
      end
      ACT_RESET_CNT: begin
        drop_total  = '0;
        merge_total = '0;
      end
      ACT_QUIT: begin
        quit_raised = 1'b1;
        store_event(KIND_QUIT, '0, '0, '0, '0, '0, '0);
      end
      default: begin
      end
    endcase
    rep.pending_count   = 6'((tail_pos + QUEUE_DEPTH - head_pos) % QUEUE_DEPTH);
    rep.dropped_count   = drop_total;
    rep.coalesced_count = merge_total;
    rep.quit_flag       = quit_raised;
    return rep;
  endfunction

  function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      failures++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head_pos    = 0;
      tail_pos    = 0;
      drop_total  = '0;
      merge_total = '0;
      quit_raised = 1'b0;
      predicted_replies.delete();
    end else begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          failures++;
          $error("result transfer with no command outstanding");
        end else begin
          oldest = predicted_replies.pop_front();
          check_field("popped_valid", oldest.popped_valid, result.popped_valid);
          check_field("out_kind", oldest.out_kind, result.out_kind);
          check_field("out_window", oldest.out_window, result.out_window);
          check_field("out_width", oldest.out_width, result.out_width);
          check_field("out_height", oldest.out_height, result.out_height);
          check_field("out_code", oldest.out_code, result.out_code);
          check_field("out_x", oldest.out_x, result.out_x);
          check_field("out_y", oldest.out_y, result.out_y);
          check_field("pending_count", oldest.pending_count, result.pending_count);
          check_field("dropped_count", oldest.dropped_count, result.dropped_count);
          check_field("coalesced_count", oldest.coalesced_count, result.coalesced_count);
          check_field("quit_flag", oldest.quit_flag, result.quit_flag);
        end
      end
      if (start && !busy) begin
        predicted_replies.insert(predicted_replies.size(), predict_reply(request));
      end
    end
    outstanding = predicted_replies.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for coalescing_event_queue: clock, reset, directed and random commands, verdict.
// Depends on ceq_pkg, the coalescing_event_queue RTL and ceq_reply_checker.
`timescale 1ns / 1ps

module tb_top;
  import ceq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam logic [3:0] KIND_KEYDOWN  = 4'd6;
  localparam logic [3:0] KIND_KEYUP    = 4'd7;
  localparam logic [3:0] KIND_MOVE     = 4'd8;
  localparam logic [3:0] KIND_BTNDOWN  = 4'd9;
  localparam logic [3:0] KIND_BTNUP    = 4'd10;
  localparam logic [3:0] KIND_RAWDELTA = 4'd11;
  localparam logic [3:0] KIND_SPARE    = 4'd15;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  in_t  request = '0;
  logic busy;
  logic done;
  out_t result;
  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  int   burst_left  = 4;

  always #10 clk = ~clk;

  coalescing_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  ceq_reply_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) reply_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .failures(failures),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t make_cmd(logic [2:0] act, logic [3:0] kind, logic hasw,
                                   logic [4:0] wid, logic [15:0] w, logic [15:0] h,
                                   logic [31:0] code, logic [31:0] x, logic [31:0] y);
    in_t cmd;
    cmd.action     = act;
    cmd.event_kind = kind;
    cmd.has_window = hasw;
    cmd.window_id  = wid;
    cmd.new_width  = w;
    cmd.new_height = h;
    cmd.code       = code;
    cmd.pointer_x  = x;
    cmd.pointer_y  = y;
    return cmd;
  endfunction

  // Holds start high until the transfer, then either keeps the burst going or idles.
  task automatic send_cmd(input in_t cmd);
    int gap;
    start   <= 1'b1;
    request <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  initial begin
    in_t cmd;
    int  counted;
    int  mode;
    int  len;
    int  push_pct;
    int  pop_pct;
    int  roll;
    int  n;
    bit  noise;
    bit  ignored;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_cmd(make_cmd(ACT_POP, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_NONE, 1, 3, 10, 10, 1, 1, 1));
    send_cmd(make_cmd(ACT_PUSH, KIND_SPARE, 1, 3, 10, 10, 1, 1, 1));
    send_cmd(make_cmd(ACT_PUSH, KIND_CLOSE, 0, 3, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_RESIZE, 0, 3, 50, 60, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_KEYDOWN, 1, 31, 16'hffff, 16'hffff, 32'hffff_ffff,
                      32'h7fff_ffff, 32'h8000_0000));
    send_cmd(make_cmd(ACT_PUSH, KIND_RESIZE, 1, 0, 1, 1, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_RESIZE, 1, 0, 16'hffff, 16'hffff, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_RESIZE, 1, 0, 0, 10, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_RESIZE, 1, 0, 5, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_MOVE, 0, 7, 0, 0, 0, 32'hffff_ffff, 32'h0));
    send_cmd(make_cmd(ACT_PUSH, KIND_FOCUS_GAINED, 1, 5, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_FOCUS_LOST, 1, 5, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_BTNDOWN, 1, 2, 0, 0, 1, 100, 200));
    send_cmd(make_cmd(ACT_PUSH, KIND_BTNUP, 1, 2, 0, 0, 5, 100, 200));
    send_cmd(make_cmd(ACT_PUSH, KIND_KEYUP, 1, 31, 0, 0, 32'h0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_RAWDELTA, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff));
    send_cmd(make_cmd(ACT_PUSH, KIND_CLOSE, 1, 31, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_SPARE_FIRST, KIND_RESIZE, 1, 1, 9, 9, 0, 0, 0));
    send_cmd(make_cmd(ACT_SPARE_LAST, KIND_RESIZE, 1, 1, 9, 9, 0, 0, 0));
    send_cmd(make_cmd(ACT_QUIT, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_POP, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_CLEAR, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_RESET_CNT, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_PUSH, KIND_QUIT, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(ACT_POP, KIND_NONE, 0, 0, 0, 0, 0, 0, 0));

    // Episodes that fill the queue to overflow, drain it, or mix the two,
    // with an occasional run of unconstrained commands.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 9);
      noise = 1'b0;
      if (mode <= 3) begin
        push_pct = 85;
        pop_pct  = 10;
        len      = $urandom_range(40, 120);
      end else if (mode <= 5) begin
        push_pct = 15;
        pop_pct  = 80;
        len      = $urandom_range(10, 70);
      end else if (mode <= 8) begin
        push_pct = 50;
        pop_pct  = 40;
        len      = $urandom_range(10, 60);
      end else begin
        push_pct = 0;
        pop_pct  = 0;
        noise    = 1'b1;
        len      = $urandom_range(5, 20);
      end
      for (n = 0; n < len && counted < RANDOM_ITEMS; n++) begin
        cmd.action     = $urandom_range(0, 7);
        cmd.event_kind = $urandom_range(0, 15);
        cmd.has_window = $urandom_range(0, 1);
        cmd.window_id  = $urandom_range(0, 31);
        cmd.new_width  = $urandom;
        cmd.new_height = $urandom;
        cmd.code       = $urandom;
        cmd.pointer_x  = $urandom;
        cmd.pointer_y  = $urandom;
        if (!noise) begin
          roll = $urandom_range(0, 99);
          if (roll < push_pct) begin
            cmd.action = ACT_PUSH;
            roll = $urandom_range(0, 99);
            if (roll < 40) cmd.event_kind = KIND_RESIZE;
            else if (roll >= 44) cmd.event_kind = $urandom_range(KIND_QUIT, KIND_LAST);
            cmd.has_window = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 3) != 0) cmd.window_id = $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0) cmd.new_width = '0;
            if ($urandom_range(0, 15) == 0) cmd.new_height = '0;
          end else if (roll < push_pct + pop_pct) begin
            cmd.action = ACT_POP;
          end else begin
            roll = $urandom_range(0, 9);
            if (roll == 0) cmd.action = ACT_CLEAR;
            else if (roll <= 3) cmd.action = ACT_RESET_CNT;
            else if (roll <= 6) cmd.action = ACT_QUIT;
            else cmd.action = $urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST);
          end
        end
        ignored = cmd.action > ACT_QUIT ||
                  (cmd.action == ACT_PUSH &&
                   (cmd.event_kind == KIND_NONE || cmd.event_kind > KIND_LAST ||
                    (cmd.event_kind inside {KIND_CLOSE, KIND_RESIZE, KIND_FOCUS_GAINED,
                                            KIND_FOCUS_LOST} && !cmd.has_window)));
        send_cmd(cmd);
        if (!ignored) counted++;
      end
    end

    if (burst_left > 0) start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (QUEUE_DEPTH + 8) @(negedge clk);

    if (failures == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ceq_pkg.sv
rtl/ceq_ram.sv
rtl/coalescing_event_queue.sv
rtl/ceq_checker.sv
tb/sv/ceq_reply_checker.sv
tb/sv/tb_top.sv
